>>> sv/prat_pkg.sv
// Shared types and codes for the process region address translator.
`timescale 1ns / 1ps
package prat_pkg;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_LOOKUP = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESP
	} back_state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [21:0] process_id;
		logic [63:0] address;
		logic [63:0] region_length;
		logic [63:0] page_offset;
		logic [63:0] inode_number;
		logic [11:0] device_major;
		logic [19:0] device_minor;
		logic [63:0] inode_generation;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] file_offset;
		logic [63:0] found_inode;
		logic [11:0] found_major;
		logic [19:0] found_minor;
		logic [63:0] found_generation;
	} out_word_t;

	// One stored region.
	typedef struct packed {
		logic [21:0] pid;
		logic [63:0] start_addr;
		logic [63:0] end_addr;
		logic [63:0] pgoff;
		logic [63:0] inode;
		logic [11:0] major;
		logic [19:0] minor;
		logic [63:0] generation;
	} entry_t;

	// Classified command handed from front to back.
	typedef struct packed {
		func_t  op;
		logic [63:0] address;
		entry_t ent;
	} cmd_t;

endpackage

>>> sv/prat_front.sv
// Front end: accepts words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module prat_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  prat_pkg::in_word_t req,
	output logic              q_valid,
	output prat_pkg::cmd_t    q_cmd,
	input  logic              q_pop
);
	import prat_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       cmd_in;

	// Classify the word and compute the region end.
	always_comb begin
		cmd_in.op             = func_t'(req.func);
		cmd_in.address        = req.address;
		cmd_in.ent.pid        = req.process_id;
		cmd_in.ent.start_addr = req.address;
		cmd_in.ent.end_addr   = req.address + req.region_length;
		cmd_in.ent.pgoff      = req.page_offset;
		cmd_in.ent.inode      = req.inode_number;
		cmd_in.ent.major      = req.device_major;
		cmd_in.ent.minor      = req.device_minor;
		cmd_in.ent.generation = req.inode_generation;
	end

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_cmd   = slot_q[rd_ptr_q];

	// Hold queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/prat_back.sv
// Back end: region table memory, insert, compacting remove and lookup scan.
`timescale 1ns / 1ps
module prat_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  prat_pkg::cmd_t     q_cmd,
	output logic               q_pop,
	output logic               rsp_valid,
	output prat_pkg::out_word_t rsp
);
	import prat_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	back_state_t state_q, state_nxt;

	entry_t          mem [TABLE_ENTRIES];
	entry_t          rdata_s1;
	logic            rv_s1;
	cmd_t            cmd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   rd_q;
	logic [CW-1:0]   keep_q;
	logic [63:0]     diff_q;
	entry_t          hit_q;

	logic            issue;
	logic            hit;
	logic            keep_it;
	logic            scan_end;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	entry_t          mem_wdata;
	logic            rsp_set;
	out_word_t       rsp_nxt;
	out_word_t       rsp_q;
	logic            rsp_valid_q;

	assign issue    = (state_q == BK_SCAN) && (rd_q < cnt_q);
	assign hit      = rv_s1 && (rdata_s1.pid == cmd_q.ent.pid)
	                  && (cmd_q.address >= rdata_s1.start_addr)
	                  && (cmd_q.address < rdata_s1.end_addr);
	assign keep_it  = rv_s1 && (rdata_s1.pid != cmd_q.ent.pid);
	assign scan_end = !issue && !rv_s1;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && (q_cmd.op == FN_REMOVE || q_cmd.op == FN_LOOKUP)) begin
					state_nxt = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (cmd_q.op == FN_LOOKUP && hit) begin
					state_nxt = BK_RESP;
				end else if (scan_end) begin
					state_nxt = BK_IDLE;
				end
			end
			BK_RESP: state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Outputs: queue pop, table write, result word.
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = q_cmd.ent;
		rsp_set   = 1'b0;
		rsp_nxt   = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.op == FN_INSERT) begin
						rsp_set = 1'b1;
						if (cnt_q == FULL_CNT) begin
							rsp_nxt.status = ST_FULL;
						end else begin
							mem_we = 1'b1;
						end
					end else if (q_cmd.op == FN_NOP) begin
						rsp_set = 1'b1;
					end
				end
			end
			BK_SCAN: begin
				if (cmd_q.op == FN_REMOVE) begin
					if (keep_it) begin
						mem_we    = 1'b1;
						mem_waddr = keep_q[AW-1:0];
						mem_wdata = rdata_s1;
					end
					if (scan_end) begin
						rsp_set = 1'b1;
					end
				end else if (!hit && scan_end) begin
					rsp_set        = 1'b1;
					rsp_nxt.status = ST_MISS;
				end
			end
			BK_RESP: begin
				rsp_set                  = 1'b1;
				rsp_nxt.file_offset      = diff_q + hit_q.pgoff;
				rsp_nxt.found_inode      = hit_q.inode;
				rsp_nxt.found_major      = hit_q.major;
				rsp_nxt.found_minor      = hit_q.minor;
				rsp_nxt.found_generation = hit_q.generation;
			end
			default: ;
		endcase
	end

	// Table memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rdata_s1 <= mem[rd_q[AW-1:0]];
		end
	end

	// Latch command and hit data.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (hit) begin
			diff_q <= cmd_q.address - rdata_s1.start_addr;
			hit_q  <= rdata_s1;
		end
		rsp_q <= rsp_nxt;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			rd_q        <= '0;
			keep_q      <= '0;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= rsp_set;
			// issue is low outside the scan, so this also clears it in idle
			rv_s1       <= issue && !(cmd_q.op == FN_LOOKUP && hit);
			if (state_q == BK_IDLE) begin
				rd_q   <= '0;
				keep_q <= '0;
				if (mem_we) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (state_q == BK_SCAN) begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (keep_it && cmd_q.op == FN_REMOVE) begin
					keep_q <= keep_q + CW'(1);
				end
				if (scan_end && cmd_q.op == FN_REMOVE) begin
					cnt_q <= keep_q;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/process_region_address_translator_top.sv
// Top level of the process region address translator.
`timescale 1ns / 1ps
// A command word is taken when start is high and busy is low; a two-word queue
// sits between the front end and the table engine, so busy rises only when
// the queue is full. Every word yields exactly one result word, shown for one
// cycle with rsp_valid high; the receiver cannot stall it. An insert or an
// unused code is answered without a table scan; a lookup or a remove is paced
// by the single read port of the region table, which is scanned one entry per
// cycle. No clearing pass after reset.
module process_region_address_translator_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  prat_pkg::in_word_t  req,
	output logic                rsp_valid,
	output prat_pkg::out_word_t rsp
);
	import prat_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	prat_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	prat_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> bench/process_region_address_translator_top_tb.sv
// Self-checking testbench for the process region address translator top level.
`timescale 1ns / 1ps
module process_region_address_translator_top_tb;
	import prat_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int NUM_RANDOM = 1950;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t req;
	logic rsp_valid;
	out_word_t rsp;

	process_region_address_translator_top #(.TABLE_ENTRIES(TABLE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	// Shadow copy of the region table
	entry_t shadow_tbl[TABLE_DEPTH];
	int shadow_used;

	out_word_t pending_rsp[$];
	int error_count;
	int cycle_count;
	bit quiet_phase;

	// Directed stimulus; use_fixed marks rows whose answer is typed in
	typedef struct {
		in_word_t word;
		bit use_fixed;
		out_word_t fixed;
	} dir_row_t;
	dir_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compute the expected answer and advance the shadow table
	function automatic out_word_t translate_word(in_word_t w);
		out_word_t r;
		int keep;
		r = '0;
		r.status = ST_OK;
		case (w.func)
			FN_INSERT: begin
				if (shadow_used >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_tbl[shadow_used].pid = w.process_id;
					shadow_tbl[shadow_used].start_addr = w.address;
					shadow_tbl[shadow_used].end_addr = w.address + w.region_length;
					shadow_tbl[shadow_used].pgoff = w.page_offset;
					shadow_tbl[shadow_used].inode = w.inode_number;
					shadow_tbl[shadow_used].major = w.device_major;
					shadow_tbl[shadow_used].minor = w.device_minor;
					shadow_tbl[shadow_used].generation = w.inode_generation;
					shadow_used++;
				end
			end
			FN_REMOVE: begin
				keep = 0;
				for (int i = 0; i < shadow_used; i++) begin
					if (shadow_tbl[i].pid != w.process_id) begin
						shadow_tbl[keep] = shadow_tbl[i];
						keep++;
					end
				end
				shadow_used = keep;
			end
			FN_LOOKUP: begin
				r.status = ST_MISS;
				for (int i = 0; i < shadow_used; i++) begin
					if (shadow_tbl[i].pid == w.process_id &&
						w.address >= shadow_tbl[i].start_addr &&
						w.address < shadow_tbl[i].end_addr) begin
						r.status = ST_OK;
						r.file_offset = w.address - shadow_tbl[i].start_addr + shadow_tbl[i].pgoff;
						r.found_inode = shadow_tbl[i].inode;
						r.found_major = shadow_tbl[i].major;
						r.found_minor = shadow_tbl[i].minor;
						r.found_generation = shadow_tbl[i].generation;
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Build a word with random payload; pick_pid draws pids from a small pool so lookups and removes hit
	function automatic in_word_t make_word(func_t f, logic [21:0] pid,
		logic [63:0] addr, logic [63:0] len);
		in_word_t w;
		w.func = f;
		w.process_id = pid;
		w.address = addr;
		w.region_length = len;
		w.page_offset = rand64();
		w.inode_number = rand64();
		w.device_major = 12'($urandom());
		w.device_minor = 20'($urandom());
		w.inode_generation = rand64();
		return w;
	endfunction

	function automatic logic [21:0] pick_pid();
		if ($urandom_range(0, 9) == 0)
			return 22'($urandom());
		return $urandom_range(0, 5) == 5 ? 22'h3FFFFF : 22'($urandom_range(0, 4));
	endfunction

	// Pick a random word; a lookup address usually falls inside some stored region
	function automatic in_word_t random_word();
		in_word_t w;
		int k;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			w = make_word(FN_INSERT, pick_pid(), rand64(),
				$urandom_range(0, 3) == 0 ? rand64() : 64'($urandom_range(1, 65536)));
		end else if (sel < 85) begin
			w = make_word(FN_LOOKUP, pick_pid(), rand64(), rand64());
			if (shadow_used > 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, shadow_used - 1);
				w.process_id = shadow_tbl[k].pid;
				w.address = shadow_tbl[k].start_addr +
					64'($urandom_range(0, 70000)) - 64'($urandom_range(0, 2));
			end
		end else if (sel < 97) begin
			w = make_word(FN_REMOVE, pick_pid(), rand64(), rand64());
		end else begin
			w = make_word(FN_NOP, 22'($urandom()), rand64(), rand64());
		end
		return w;
	endfunction

	// Present one word and hold it until accepted; start stays high after
	task automatic send_word(in_word_t w);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		pending_rsp.push_back(translate_word(w));
	endtask

	// Drop start before a pause in the stream
	task automatic idle_bus();
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(in_word_t w, bit fixed_on, logic [1:0] st);
		dir_row_t row;
		row.word = w;
		row.use_fixed = fixed_on;
		row.fixed = '0;
		row.fixed.status = st;
		dir_rows.push_back(row);
	endtask

	// Compare results against the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && rsp_valid) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result word");
				error_count++;
			end else begin
				exp_w = pending_rsp.pop_front();
				if (rsp.status !== exp_w.status) begin
					$error("status exp %0d got %0d", exp_w.status, rsp.status);
					error_count++;
				end
				if (rsp.file_offset !== exp_w.file_offset) begin
					$error("file_offset exp %h got %h", exp_w.file_offset, rsp.file_offset);
					error_count++;
				end
				if (rsp.found_inode !== exp_w.found_inode) begin
					$error("found_inode exp %h got %h", exp_w.found_inode, rsp.found_inode);
					error_count++;
				end
				if (rsp.found_major !== exp_w.found_major) begin
					$error("found_major exp %h got %h", exp_w.found_major, rsp.found_major);
					error_count++;
				end
				if (rsp.found_minor !== exp_w.found_minor) begin
					$error("found_minor exp %h got %h", exp_w.found_minor, rsp.found_minor);
					error_count++;
				end
				if (rsp.found_generation !== exp_w.found_generation) begin
					$error("found_generation exp %h got %h",
						exp_w.found_generation, rsp.found_generation);
					error_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("process_region_address_translator_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		in_word_t w;
		error_count = 0;
		cycle_count = 0;
		quiet_phase = 1'b0;
		shadow_used = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, wrap, empty region, nop, absent remove
		add_row(make_word(FN_LOOKUP, 22'd1, 64'h0, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_REMOVE, 22'd9, 64'h0, 64'h0), 1'b1, ST_OK);
		add_row(make_word(FN_NOP, 22'h3FFFFF, '1, '1), 1'b1, ST_OK);
		w = make_word(FN_INSERT, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF);
		w.page_offset = '1; w.inode_number = '1; w.device_major = '1;
		w.device_minor = '1; w.inode_generation = '1;
		add_row(w, 1'b1, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0), 1'b0, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_LOOKUP, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FF00, 64'h0), 1'b0, ST_OK);
		add_row(make_word(FN_INSERT, 22'd0, 64'h0, 64'h0), 1'b1, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd0, 64'h0, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_INSERT, 22'd0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20), 1'b1, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd0, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_INSERT, 22'd0, 64'h1000, 64'h1000), 1'b1, ST_OK);
		add_row(make_word(FN_INSERT, 22'd0, 64'h1800, 64'h1000), 1'b1, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd0, 64'h1900, 64'h0), 1'b0, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd0, 64'h2000, 64'h0), 1'b0, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd1, 64'h1900, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_REMOVE, 22'd0, 64'h0, 64'h0), 1'b1, ST_OK);
		add_row(make_word(FN_LOOKUP, 22'd0, 64'h1900, 64'h0), 1'b1, ST_MISS);
		add_row(make_word(FN_LOOKUP, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FF10, 64'h0), 1'b0, ST_OK);
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].word);
			if (dir_rows[i].use_fixed && pending_rsp[$] != dir_rows[i].fixed) begin
				$error("directed row %0d: table answer disagrees with shadow", i);
				error_count++;
			end
		end

		// Fill the table past full, then check the rejection and clear it
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			send_word(make_word(FN_INSERT, 22'd7, 64'(i) << 12, 64'h1000));
		send_word(make_word(FN_LOOKUP, 22'd7, 64'h3F800, 64'h0));
		send_word(make_word(FN_REMOVE, 22'd7, 64'h0, 64'h0));
		idle_bus();
		wait_drained();
		// Hold off until the table has answered everything
		repeat (DRAIN_CYCLES) @(posedge clk);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM - 200)
				quiet_phase = 1'b1;
			send_word(random_word());
		end
		idle_bus();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_rsp.size() == 0)
			$display("process_region_address_translator_top_tb: done, clean");
		else
			$display("process_region_address_translator_top_tb: done, errors");
		$finish;
	end
endmodule
